// ===== rtl/ldnw_pkg.sv =====
// shared types and constants for the lcd decimal number writer
`default_nettype none

package ldnw_pkg;

    // fixed field widths
    localparam int unsigned NUM_W    = 32;
    localparam int unsigned COL_W    = 6;
    localparam int unsigned BASE_W   = COL_W + 1;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BCD_DIGS = 10;
    localparam int unsigned BCD_W    = 4 * BCD_DIGS;
    localparam int unsigned BITC_W   = 5;

    // lcd bus codes
    localparam logic [BYTE_W-1:0] DDRAM_CMD  = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture a new number
        logic step;      // one shift-add-3 conversion step
        logic count;     // size the digit run
        logic sel_data;  // present the character write, else the address write
        logic advance;   // move to the next digit
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic conv_done;   // last conversion step in progress
        logic last_digit;  // current digit is the least significant one
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/lcd_decimal_number_writer.sv =====
// lcd decimal number writer: 32-bit number to a run of address and character writes
// the first write follows 32 shift-add-3 conversion steps and one step that sizes the digit run
// a new number is taken only back in idle, once every write of the last one has been accepted
// reset: synchronous active low, returns the sequencer to idle ready for input
`default_nettype none

module lcd_decimal_number_writer #(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input stream
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire [39:0] i_s_tdata,   // number [31:0], column [37:32], zero [39:38]
    input  wire        i_s_tuser,   // row
    // output stream
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata,   // bus_byte [7:0]
    output logic       o_m_tuser,   // reg_select
    output logic       o_m_tlast    // last
);

    ldnw_pkg::t_cmd  w_cmd;
    ldnw_pkg::t_stat w_stat;

    ldnw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_m_ready (i_m_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid)
    );

    ldnw_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_number     (i_s_tdata[31:0]),
        .i_row        (i_s_tuser),
        .i_column     (i_s_tdata[37:32]),
        .o_stat       (w_stat),
        .o_reg_select (o_m_tuser),
        .o_bus_byte   (o_m_tdata),
        .o_last       (o_m_tlast)
    );

    // input is never taken while writes are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_m_tvalid && o_s_tready))
        else $error("input ready while output valid");

    // an accepted number is converted before any write appears
    a_conv_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_m_tvalid)
        else $error("write issued before conversion");

    // address writes carry the set-ddram command bit
    a_cmd_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[7] && !o_m_tlast))
        else $error("bad address write");

    // character writes are decimal digits
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata >= 8'h30 && o_m_tdata <= 8'h39))
        else $error("character write out of range");

    // the final transaction of a run returns to idle
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("not idle after last write");

endmodule

`default_nettype wire

// ===== rtl/ldnw_ctrl.sv =====
// sequencer for conversion and emission of lcd bus writes
`default_nettype none

module ldnw_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_s_valid,
    input  wire             i_m_ready,
    input  ldnw_pkg::t_stat i_stat,
    output ldnw_pkg::t_cmd  o_cmd,
    output logic            o_s_ready,
    output logic            o_m_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_CMD   = 3'd3;
    localparam logic [2:0] S_DATA  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_out_hs;

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = (r_state == S_CMD) || (r_state == S_DATA);
    assign w_out_hs  = o_m_valid && i_m_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_stat.conv_done) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = S_CMD;
            end
            S_CMD: begin
                if (w_out_hs) begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                o_cmd.sel_data = 1'b1;
                if (w_out_hs) begin
                    o_cmd.advance = 1'b1;
                    n_state       = i_stat.last_digit ? S_IDLE : S_CMD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ldnw_dp.sv =====
// binary to bcd conversion and lcd write formatting
`default_nettype none

module ldnw_dp #(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire                            i_clk,
    input  ldnw_pkg::t_cmd                 i_cmd,
    input  wire [ldnw_pkg::NUM_W-1:0]      i_number,
    input  wire                            i_row,
    input  wire [ldnw_pkg::COL_W-1:0]      i_column,
    output ldnw_pkg::t_stat                o_stat,
    output logic                           o_reg_select,
    output logic [ldnw_pkg::BYTE_W-1:0]    o_bus_byte,
    output logic                           o_last
);

    // digits actually kept and shown
    localparam int unsigned KEEP = (MAX_DIGITS < ldnw_pkg::BCD_DIGS) ?
                                   MAX_DIGITS : ldnw_pkg::BCD_DIGS;
    localparam int unsigned CW   = $clog2(KEEP + 1);

    logic [ldnw_pkg::NUM_W-1:0]  r_bin;
    logic [ldnw_pkg::BCD_W-1:0]  r_bcd;
    logic [ldnw_pkg::BITC_W-1:0] r_bit_cnt;
    logic [ldnw_pkg::BASE_W-1:0] r_base;
    logic [CW-1:0]               r_idx;
    logic [CW-1:0]               r_pos;

    logic [ldnw_pkg::BCD_W-1:0]  w_adj;
    logic [3:0]                  w_nd;
    logic [CW-1:0]               w_cnt;
    logic [3:0]                  w_dig;
    logic [ldnw_pkg::BYTE_W-1:0] w_addr;

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb begin
        logic [3:0] d;
        d = '0;
        for (int k = 0; k < ldnw_pkg::BCD_DIGS; k++) begin
            d = r_bcd[4*k +: 4];
            w_adj[4*k +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    // number of significant digits, clamped to the kept ones
    always_comb begin
        w_nd = 4'd1;
        for (int k = 1; k < ldnw_pkg::BCD_DIGS; k++) begin
            if (r_bcd[4*k +: 4] != 4'd0) begin
                w_nd = 4'(k + 1);
            end
        end
        if (w_nd > 4'(KEEP)) begin
            w_cnt = CW'(KEEP);
        end else begin
            w_cnt = CW'(w_nd);
        end
    end

    // digit under emission
    always_comb begin
        w_dig = 4'd0;
        for (int k = 0; k < KEEP; k++) begin
            if (r_idx == CW'(k)) begin
                w_dig = r_bcd[4*k +: 4];
            end
        end
    end

    // ddram address wraps at 256, bit 7 forced by the command code
    assign w_addr = {1'b0, r_base} + ldnw_pkg::BYTE_W'(r_pos);

    assign o_reg_select = i_cmd.sel_data;
    assign o_bus_byte   = i_cmd.sel_data ? (ldnw_pkg::ASCII_ZERO + {4'd0, w_dig})
                                         : (ldnw_pkg::DDRAM_CMD | w_addr);
    assign o_last       = i_cmd.sel_data && (r_idx == '0);

    assign o_stat.conv_done  = (r_bit_cnt == {ldnw_pkg::BITC_W{1'b1}});
    assign o_stat.last_digit = (r_idx == '0);

    // conversion and emission registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin     <= i_number;
            r_bcd     <= '0;
            r_bit_cnt <= '0;
            r_base    <= {i_row, i_column};
        end else if (i_cmd.step) begin
            r_bcd     <= {w_adj[ldnw_pkg::BCD_W-2:0], r_bin[ldnw_pkg::NUM_W-1]};
            r_bin     <= {r_bin[ldnw_pkg::NUM_W-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt + 1'b1;
        end
        if (i_cmd.count) begin
            r_idx <= w_cnt - 1'b1;
            r_pos <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx - 1'b1;
            r_pos <= r_pos + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== test/lcd_write_checker.sv =====
// checker for the lcd decimal number writer: predicts and compares the lcd bus writes
module lcd_write_checker #(
    parameter int unsigned MAX_DIGITS = 10
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input stream, as seen by the block
    input  wire                          i_s_tvalid,
    input  wire                          i_s_tready,
    input  wire [39:0]                   i_s_tdata,   // number [31:0], column [37:32], zero [39:38]
    input  wire                          i_s_tuser,   // row
    // output stream, as seen by the block
    input  wire                          i_m_tvalid,
    input  wire                          i_m_tready,
    input  wire [ldnw_pkg::BYTE_W-1:0]   i_m_tdata,   // bus_byte [7:0]
    input  wire                          i_m_tuser,   // reg_select
    input  wire                          i_m_tlast,   // last
    // status for the testbench top
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_numbers_seen,
    output int                           o_writes_seen
);

    localparam logic [ldnw_pkg::BYTE_W-1:0] LINE2_BASE = 8'h40;
    localparam int unsigned                 RADIX      = 10;

    typedef struct packed {
        logic                        reg_select;
        logic [ldnw_pkg::BYTE_W-1:0] bus_byte;
        logic                        last;
    } t_lcd_write;

    t_lcd_write expected_writes[$];

    // expand one number into its address and character writes, most significant digit first
    task automatic queue_number_writes(input logic [ldnw_pkg::NUM_W-1:0] num, input logic row,
                                       input logic [ldnw_pkg::COL_W-1:0] col);
        logic [3:0]                  digs [MAX_DIGITS];
        logic [ldnw_pkg::NUM_W-1:0]  rest;
        int                          cnt;
        logic [ldnw_pkg::BYTE_W-1:0] addr;
        t_lcd_write                  wr;
        rest = num;
        cnt  = 0;
        // least significant first; zero still gives one digit, excess high digits dropped
        do begin
            if (cnt < MAX_DIGITS) begin
                digs[cnt] = 4'(rest % RADIX);
                cnt++;
            end
            rest = rest / RADIX;
        end while (rest != 0);
        for (int i = cnt - 1; i >= 0; i--) begin
            // address wraps at 8 bits, then the command bit is forced on
            addr = (row ? LINE2_BASE : 8'h00) + ldnw_pkg::BYTE_W'(col)
                   + ldnw_pkg::BYTE_W'(cnt - 1 - i);
            wr.reg_select = 1'b0;
            wr.bus_byte   = addr | ldnw_pkg::DDRAM_CMD;
            wr.last       = 1'b0;
            expected_writes.push_back(wr);
            wr.reg_select = 1'b1;
            wr.bus_byte   = ldnw_pkg::ASCII_ZERO + ldnw_pkg::BYTE_W'(digs[i]);
            wr.last       = (i == 0);
            expected_writes.push_back(wr);
        end
    endtask

    // watch both channels on every rising edge
    always @(posedge i_clk) begin
        t_lcd_write got;
        t_lcd_write want;
        if (!i_rst_n) begin
            expected_writes.delete();
            o_fail_count   <= 0;
            o_pending      <= 0;
            o_numbers_seen <= 0;
            o_writes_seen  <= 0;
        end else begin
            // input transaction: predict its writes
            if (i_s_tvalid && i_s_tready) begin
                queue_number_writes(i_s_tdata[ldnw_pkg::NUM_W-1:0], i_s_tuser,
                                    i_s_tdata[ldnw_pkg::NUM_W+ldnw_pkg::COL_W-1:ldnw_pkg::NUM_W]);
                o_numbers_seen <= o_numbers_seen + 1;
            end
            // output transaction: compare with the oldest expected write
            if (i_m_tvalid && i_m_tready) begin
                got.reg_select = i_m_tuser;
                got.bus_byte   = i_m_tdata;
                got.last       = i_m_tlast;
                o_writes_seen <= o_writes_seen + 1;
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected write: expected none, got rs=%0b byte=%02h last=%0b",
                             $time, got.reg_select, got.bus_byte, got.last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_writes.pop_front();
                    if (got.reg_select !== want.reg_select || got.bus_byte !== want.bus_byte
                        || got.last !== want.last) begin
                        $display("%0t: write mismatch: expected rs=%0b byte=%02h last=%0b,",
                                 $time, want.reg_select, want.bus_byte, want.last);
                        $display("    got rs=%0b byte=%02h last=%0b",
                                 got.reg_select, got.bus_byte, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_writes.size();
        end
    end

endmodule

// ===== test/tb_lcd_decimal_number_writer.sv =====
// testbench top for the lcd decimal number writer: stimulus, output flow control and verdict
module tb_lcd_decimal_number_writer;

    localparam int unsigned MAX_DIGITS     = 10;
    localparam int          RANDOM_ITEMS   = 120;
    localparam int          HOLD_AT_ITEM   = 40;
    localparam int          CALM_AT_ITEM   = 100;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_CYCLES   = 60;
    localparam int          TIMEOUT_CYCLES = 600000;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic [39:0]                 i_s_tdata  = '0;
    logic                        i_s_tuser  = 1'b0;
    logic                        i_m_tready = 1'b0;
    logic                        o_s_tready;
    logic                        o_m_tvalid;
    logic [ldnw_pkg::BYTE_W-1:0] o_m_tdata;
    logic                        o_m_tuser;
    logic                        o_m_tlast;

    wire [31:0] fail_count;
    wire [31:0] pending;
    wire [31:0] numbers_seen;
    wire [31:0] writes_seen;

    // idling controls for the sender and the receiver, set by the stimulus
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    always #1 i_clk = ~i_clk;

    lcd_decimal_number_writer #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    lcd_write_checker #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .i_m_tuser      (o_m_tuser),
        .i_m_tlast      (o_m_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_numbers_seen (numbers_seen),
        .o_writes_seen  (writes_seen)
    );

    // offer one number and wait for its transaction, then maybe idle a while
    task automatic send_number(input logic [ldnw_pkg::NUM_W-1:0] num, input logic row,
                               input logic [ldnw_pkg::COL_W-1:0] col);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, col, num};
        i_s_tuser  <= row;
        do @(posedge i_clk); while (!o_s_tready);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // random value, weighted toward every digit count and the decade edges
    function automatic logic [ldnw_pkg::NUM_W-1:0] pick_number();
        longint lo;
        longint hi;
        longint p;
        int     d;
        p = 1;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                d = $urandom_range(1, 10);
                repeat (d - 1) p = p * 10;
                lo = (d == 1) ? 0 : p;
                hi = p * 10 - 1;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                return ldnw_pkg::NUM_W'(lo + ({32'd0, $urandom} % (hi - lo + 1)));
            end
            2: return $urandom_range(0, 99);
            default: begin
                repeat ($urandom_range(0, 9)) p = p * 10;
                return ldnw_pkg::NUM_W'(p - $urandom_range(0, 1));
            end
        endcase
    endfunction

    // output side flow control, with one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // run limit
    initial begin
        #(2 * TIMEOUT_CYCLES);
        $display("%0t: timeout, %0d writes still expected", $time, pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus and verdict
    initial begin
        logic [ldnw_pkg::COL_W-1:0] col;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, single digits, decade edges, full range, columns past the line
        send_number(32'd0,          1'b0, 6'd0);
        send_number(32'd1,          1'b1, 6'd0);
        send_number(32'd9,          1'b0, 6'd5);
        send_number(32'd10,         1'b1, 6'd38);
        send_number(32'd99,         1'b0, 6'd39);
        send_number(32'd100,        1'b1, 6'd20);
        send_number(32'd999999999,  1'b0, 6'd0);
        send_number(32'd1000000000, 1'b1, 6'd30);
        send_number(32'hFFFF_FFFF,  1'b0, 6'd39);
        send_number(32'hFFFF_FFFF,  1'b1, 6'd63);
        send_number(32'h8000_0000,  1'b0, 6'd40);
        send_number(32'd123456789,  1'b1, 6'd55);
        send_number(32'd12345,      1'b0, 6'd63);
        send_number(32'd0,          1'b1, 6'd63);
        send_number(32'h5555_5555,  1'b0, 6'd21);
        send_number(32'hAAAA_AAAA,  1'b1, 6'd42);

        // random numbers, rows and columns
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM) hold_req = 1'b1;
            if (n == CALM_AT_ITEM) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            col = ($urandom_range(0, 4) == 0) ? ldnw_pkg::COL_W'($urandom_range(40, 63))
                                              : ldnw_pkg::COL_W'($urandom_range(0, 39));
            send_number(pick_number(), 1'($urandom_range(0, 1)), col);
        end
        i_s_tvalid <= 1'b0;

        // drain, once the last prediction has reached the pending count
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d numbers and %0d lcd writes, with random stalls on both sides",
                 numbers_seen, writes_seen);
        $display("and one long output hold-off that backed up the input");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== lcd_decimal_number_writer.f =====
rtl/ldnw_pkg.sv
rtl/ldnw_ctrl.sv
rtl/ldnw_dp.sv
rtl/lcd_decimal_number_writer.sv
test/lcd_write_checker.sv
test/tb_lcd_decimal_number_writer.sv
